@@ rtl/core/xfr_pkg.sv @@
// Shared types, codes and helpers for the x86 flags register unit.
package xfr_pkg;

  // Operation codes carried by each input item
  typedef enum logic [3:0] {
    OP_RESULT  = 4'd0,
    OP_STC     = 4'd1,
    OP_CLC     = 4'd2,
    OP_CMC     = 4'd3,
    OP_STD     = 4'd4,
    OP_CLD     = 4'd5,
    OP_STI     = 4'd6,
    OP_CLI     = 4'd7,
    OP_LAHF    = 4'd8,
    OP_SAHF    = 4'd9,
    OP_WRITE16 = 4'd10,
    OP_WRITE32 = 4'd11,
    OP_READ    = 4'd12
  } op_e;

  // Result size codes
  typedef enum logic [1:0] {
    SIZE_BYTE  = 2'd0,
    SIZE_WORD  = 2'd1,
    SIZE_DWORD = 2'd2
  } size_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_PROTECTED_MODE        = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_VIRTUAL_MODE_EXT      = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PROTECTED_VIRTUAL_INT = 2'd2;

  localparam int unsigned EflagsW = 18;

  // Input item
  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] result_value;
    logic [1:0]  result_size;
    logic [31:0] write_value;
    logic [7:0]  ah_value;
    logic [1:0]  current_privilege;
    logic        virtual_pending;
  } xfr_in_t;

  // Result item
  typedef struct packed {
    logic [EflagsW-1:0] eflags_out;
    logic [7:0]         ah_out;
    logic               gp_fault;
    logic               interrupt_shadow;
    logic               virtual_if_out;
  } xfr_out_t;

  // Architectural flag state
  typedef struct packed {
    logic       cf;
    logic       pf;
    logic       af;
    logic       zf;
    logic       sf;
    logic       tf;
    logic       ie;
    logic       df;
    logic       of;
    logic [1:0] iopl;
    logic       nt;
    logic       rf;
    logic       vm;
    logic       vif;
  } flags_t;

  // Control register bits seen by STI/CLI
  typedef struct packed {
    logic pe;
    logic vme;
    logic pvi;
  } cfg_t;

  // Even parity of a byte: 1 when the count of set bits is even
  function automatic logic even_parity8(input logic [7:0] v);
    even_parity8 = ~(^v);
  endfunction

  // Eflags image, bit 1 always set, bits 3, 5 and 15 clear
  function automatic logic [EflagsW-1:0] eflags_image(input flags_t f);
    eflags_image = {f.vm, f.rf, 1'b0, f.nt, f.iopl, f.of, f.df, f.ie, f.tf,
                    f.sf, f.zf, 1'b0, f.af, 1'b0, f.pf, 1'b1, f.cf};
  endfunction

endpackage

@@ rtl/core/xfr_in_stage.sv @@
// Input register stage: holds one accepted item until the core takes it.
module xfr_in_stage import xfr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  xfr_in_t in_data_i,
  output logic    fwd_valid_o,
  input  logic    fwd_ready_i,
  output xfr_in_t fwd_data_o
);

  logic    valid_q, valid_d;
  xfr_in_t data_q;

  // Free when empty or when the held item moves on this cycle
  assign in_ready_o = ~valid_q | fwd_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload loads on every input transfer
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign fwd_valid_o = valid_q;
  assign fwd_data_o  = data_q;

endmodule

@@ rtl/core/xfr_flag_core.sv @@
// Flag state, control bits and the single-pass update logic.
module xfr_flag_core import xfr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic               cfg_wdata_i,
  input  logic               step_i,
  input  xfr_in_t            item_i,
  output xfr_out_t           result_o
);

  cfg_t   cfg_q, cfg_d;
  flags_t flags_q, flags_d;
  logic   privileged;
  logic   no_virtual;
  logic   zero_val;
  logic   sign_val;
  logic   gp;
  logic   shadow;
  logic [7:0] ah_res;

  // Control register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PROTECTED_MODE:        cfg_d.pe  = cfg_wdata_i;
        CFG_VIRTUAL_MODE_EXT:      cfg_d.vme = cfg_wdata_i;
        CFG_PROTECTED_VIRTUAL_INT: cfg_d.pvi = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Protection checks for STI/CLI
  assign privileged = ~cfg_q.pe | (flags_q.iopl >= item_i.current_privilege);
  assign no_virtual = ~cfg_q.vme & ~cfg_q.pvi;

  // Zero and sign of the sized result
  always_comb begin
    case (item_i.result_size)
      SIZE_BYTE: begin
        zero_val = (item_i.result_value[7:0] == 8'h00);
        sign_val = item_i.result_value[7];
      end
      SIZE_WORD: begin
        zero_val = (item_i.result_value[15:0] == 16'h0000);
        sign_val = item_i.result_value[15];
      end
      default: begin
        zero_val = (item_i.result_value == 32'h0000_0000);
        sign_val = item_i.result_value[31];
      end
    endcase
  end

  // Next flags and side outputs for the current item
  always_comb begin
    flags_d = flags_q;
    gp      = 1'b0;
    shadow  = 1'b0;
    ah_res  = 8'h00;
    unique case (item_i.op)
      OP_RESULT: begin
        flags_d.pf = even_parity8(item_i.result_value[7:0]);
        flags_d.zf = zero_val;
        flags_d.sf = sign_val;
      end
      OP_STC: flags_d.cf = 1'b1;
      OP_CLC: flags_d.cf = 1'b0;
      OP_CMC: flags_d.cf = ~flags_q.cf;
      OP_STD: flags_d.df = 1'b1;
      OP_CLD: flags_d.df = 1'b0;
      OP_STI: begin
        if (privileged) begin
          shadow     = flags_q.ie;
          flags_d.ie = 1'b1;
        end else if (no_virtual || item_i.virtual_pending) begin
          gp = 1'b1;
        end else begin
          flags_d.vif = 1'b1;
        end
      end
      OP_CLI: begin
        if (privileged) begin
          flags_d.ie = 1'b0;
        end else if (no_virtual) begin
          gp = 1'b1;
        end else begin
          flags_d.vif = 1'b0;
        end
      end
      OP_LAHF: begin
        ah_res = {flags_q.sf, flags_q.zf, 1'b0, flags_q.af, 1'b0, flags_q.pf,
                  1'b1, flags_q.cf};
      end
      OP_SAHF: begin
        flags_d.cf = item_i.ah_value[0];
        flags_d.pf = item_i.ah_value[2];
        flags_d.af = item_i.ah_value[4];
        flags_d.zf = item_i.ah_value[6];
        flags_d.sf = item_i.ah_value[7];
      end
      OP_WRITE16, OP_WRITE32: begin
        flags_d.cf   = item_i.write_value[0];
        flags_d.pf   = item_i.write_value[2];
        flags_d.af   = item_i.write_value[4];
        flags_d.zf   = item_i.write_value[6];
        flags_d.sf   = item_i.write_value[7];
        flags_d.tf   = item_i.write_value[8];
        flags_d.ie   = item_i.write_value[9];
        flags_d.df   = item_i.write_value[10];
        flags_d.of   = item_i.write_value[11];
        flags_d.iopl = item_i.write_value[13:12];
        flags_d.nt   = item_i.write_value[14];
        if (item_i.op == OP_WRITE32) begin
          flags_d.rf = item_i.write_value[16];
          flags_d.vm = item_i.write_value[17];
        end
      end
      default: ;  // read and unused codes change nothing
    endcase
  end

  // Result reflects the flags after this item
  assign result_o.eflags_out       = eflags_image(flags_d);
  assign result_o.ah_out           = ah_res;
  assign result_o.gp_fault         = gp;
  assign result_o.interrupt_shadow = shadow;
  assign result_o.virtual_if_out   = flags_d.vif;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= '0;
      flags_q <= '0;
    end else begin
      cfg_q <= cfg_d;
      if (step_i) begin
        flags_q <= flags_d;
      end
    end
  end

  // A fault leaves every flag as it was
  a_fault_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && gp |=> flags_q == $past(flags_q))
    else $error("flags changed on a protection fault");

  // Shadow only from an STI that found IF set, never with a fault
  a_shadow_sti: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shadow |-> item_i.op == OP_STI && flags_q.ie && !gp)
    else $error("interrupt shadow outside STI with IF set");

  // Flags only move when an item is taken
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> flags_q == $past(flags_q))
    else $error("flags changed without an item");

endmodule

@@ rtl/core/xfr_out_stage.sv @@
// Output register stage: holds one result until the receiver takes it.
module xfr_out_stage import xfr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     res_valid_i,
  output logic     res_ready_o,
  input  xfr_out_t res_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output xfr_out_t out_data_o
);

  logic     valid_q, valid_d;
  xfr_out_t data_q;

  // Accept a new result when empty or when the held one leaves now
  assign res_ready_o = ~valid_q | out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_ready_o) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && res_ready_o) begin
      data_q <= res_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

@@ rtl/core/x86_flags_register_unit.sv @@
// x86 flags register unit: top level joining input stage, flag core and output stage.
//
// Usage: each input transfer on in_valid_i/in_ready_o carries one flag
// operation (result update, STC/CLC/CMC, STD/CLD, STI/CLI, LAHF/SAHF,
// 16- or 32-bit flags write, read). Each produces exactly one result
// transfer on out_valid_o/out_ready_i with the eflags image after the
// operation, the LAHF byte, the fault and shadow indications and VIF.
// The item sits in the input register while the flag update logic feeds
// the result register. Throughput is one item per cycle while the receiver
// does not stall, set by the flag state loop in the core. The user must
// write the control bits PE, VME and PVI through the cfg_we_i port only
// while no item is in flight; the block itself does not enforce this.
// Reset clears all flags, VIF and the control bits, and empties both stages.
// When the receiver stalls, the result register holds; the input register
// takes one more item only if it was empty, after which in_ready_o
// drops until the result register frees.
module x86_flags_register_unit import xfr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  xfr_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output xfr_out_t           out_data_o
);

  logic     item_valid;
  logic     res_ready;
  xfr_in_t  item;
  xfr_out_t result;

  xfr_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .fwd_valid_o (item_valid),
    .fwd_ready_i (res_ready),
    .fwd_data_o  (item)
  );

  // Flags advance on each transfer from the input to the output stage
  xfr_flag_core u_flag_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (item_valid & res_ready),
    .item_i      (item),
    .result_o    (result)
  );

  xfr_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (item_valid),
    .res_ready_o (res_ready),
    .res_data_i  (result),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
